/* hdl/lls_pkg.sv */
// Shared types and constants for the linked-list set table.
package lls_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_ADD,
        S_REM
    } state_t;

    typedef struct packed {
        logic we_value;
        logic we_next;
        logic rd_en;
    } mem_ctl_t;

endpackage

/* hdl/lls_node_mem.sv */
// Node store: element value and next link per node, one write and one registered read port.
module lls_node_mem #(
    parameter int DEPTH   = lls_pkg::CAPACITY_DEF,
    parameter int VALUE_W = lls_pkg::VALUE_W,
    parameter int INDEX_W = $clog2(lls_pkg::CAPACITY_DEF + 1)
) (
    input  logic                     clk,
    input  lls_pkg::mem_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [VALUE_W-1:0]       wr_value,
    input  logic [INDEX_W-1:0]       wr_next,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [VALUE_W-1:0]       rd_value,
    output logic [INDEX_W-1:0]       rd_next
);
    import lls_pkg::*;

    logic [VALUE_W-1:0] value_mem [DEPTH];
    logic [INDEX_W-1:0] next_mem  [DEPTH];
    logic [VALUE_W-1:0] rd_value_reg;
    logic [INDEX_W-1:0] rd_next_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we_value)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctl.we_next)
        begin
            next_mem[wr_addr] <= wr_next;
        end
        if (ctl.rd_en)
        begin
            rd_value_reg <= value_mem[rd_addr];
            rd_next_reg  <= next_mem[rd_addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_next  = rd_next_reg;

endmodule

/* hdl/linked_list_set_table.sv */
// Set of distinct values kept as a singly linked list over a fixed node table.
//
// Command channel: cmd and value are taken at a clock edge where start is
// high and busy is low. cmd: add, remove, search (code 3 acts as search).
// Result channel: done pulses for one cycle with status (done or found,
// duplicate or absent, full), count after the command and is_empty.
// The receiver cannot stall; each item gives exactly one result.
// Flow: an item walks the list node by node (up to its whole length, less
// on an early match; not at all when empty), then passes the decide state
// and, for a change, the add or remove state. busy drops as done rises, so
// the next item may be taken in the cycle done is high. The list walk
// reads one node per cycle from the node memory, which sets the rate.
// Reset: the set is empty, the free chain runs over all nodes in order.
// Untouched nodes are tracked by a fill count, so no clearing pass runs
// and the first item is taken right after reset.
module linked_list_set_table #(
    parameter int CAPACITY   = lls_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = lls_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lls_pkg::CMD_W-1:0]           cmd,
    input  logic signed [lls_pkg::VALUE_W-1:0]  value,
    output logic                                done,
    output logic [lls_pkg::STATUS_W-1:0]        status,
    output logic [$clog2(CAPACITY+1)-1:0]       count,
    output logic                                is_empty
);
    import lls_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int VW = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [VW-1:0]        val_reg, val_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        prev_reg, prev_next;
    logic [IW-1:0]        succ_reg, succ_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [IW-1:0]        free_reg, free_next;
    logic [IW-1:0]        fill_reg, fill_next;
    logic [IW-1:0]        count_reg, count_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    mem_ctl_t             mem_ctl;
    logic [IW-1:0]        wr_idx;
    logic [VW-1:0]        wr_value;
    logic [IW-1:0]        wr_next;
    logic [IW-1:0]        rd_idx;
    logic [VW-1:0]        rd_value;
    logic [IW-1:0]        rd_next;

    lls_node_mem #(
        .DEPTH   (CAPACITY),
        .VALUE_W (VW),
        .INDEX_W (IW)
    ) u_node_mem (
        .clk      (clk),
        .ctl      (mem_ctl),
        .wr_addr  (wr_idx[AW-1:0]),
        .wr_value (wr_value),
        .wr_next  (wr_next),
        .rd_addr  (rd_idx[AW-1:0]),
        .rd_value (rd_value),
        .rd_next  (rd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            free_reg   <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        succ_reg   <= succ_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        succ_next   = succ_reg;
        found_next  = found_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mem_ctl     = '0;
        wr_idx      = cur_reg;
        wr_value    = val_reg;
        wr_next     = NIL;
        rd_idx      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    val_next   = value[VW-1:0];
                    cur_next   = head_reg;
                    prev_next  = NIL;
                    found_next = 1'b0;
                    if (head_reg != NIL)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_idx        = head_reg;
                        state_next    = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_WALK:
            begin
                if (rd_value == val_reg)
                begin
                    found_next = 1'b1;
                    succ_next  = rd_next;
                    state_next = S_DECIDE;
                end
                else if (rd_next == NIL)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    prev_next     = cur_reg;
                    cur_next      = rd_next;
                    mem_ctl.rd_en = 1'b1;
                    rd_idx        = rd_next;
                end
            end

            S_DECIDE:
            begin
                priority if (cmd_reg == CMD_ADD)
                begin
                    if (found_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        state_next  = S_IDLE;
                    end
                    else if (count_reg == NIL || free_reg == NIL)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // link old tail to the new node, fetch the free link
                        if (tail_reg != NIL)
                        begin
                            mem_ctl.we_next = 1'b1;
                            wr_idx          = tail_reg;
                            wr_next         = free_reg;
                        end
                        if (free_reg != fill_reg)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_idx        = free_reg;
                        end
                        state_next = S_ADD;
                    end
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    if (!found_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        if (prev_reg != NIL)
                        begin
                            mem_ctl.we_next = 1'b1;
                            wr_idx          = prev_reg;
                            wr_next         = succ_reg;
                        end
                        else
                        begin
                            head_next = succ_reg;
                        end
                        if (succ_reg == NIL)
                        begin
                            tail_next = prev_reg;
                        end
                        state_next = S_REM;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = found_reg ? ST_DONE : ST_MISS;
                    state_next  = S_IDLE;
                end
            end

            S_ADD:
            begin
                mem_ctl.we_value = 1'b1;
                mem_ctl.we_next  = 1'b1;
                wr_idx           = free_reg;
                wr_value         = val_reg;
                wr_next          = NIL;
                if (free_reg == fill_reg)
                begin
                    free_next = free_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    free_next = rd_next;
                end
                if (tail_reg == NIL)
                begin
                    head_next = free_reg;
                end
                tail_next   = free_reg;
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_DONE;
                state_next  = S_IDLE;
            end

            S_REM:
            begin
                mem_ctl.we_next = 1'b1;
                wr_idx          = cur_reg;
                wr_next         = free_reg;
                free_next       = cur_reg;
                count_next      = count_reg - 1'b1;
                done_next       = 1'b1;
                status_next     = ST_DONE;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign count    = count_reg;
    assign is_empty = (head_reg == NIL);

`ifndef NO_ASSERTIONS
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_DECIDE || $past(state_reg) == S_ADD ||
                      $past(state_reg) == S_REM))
        else $error("result strobe without a finishing state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("element count above capacity");

    // head moves in the cycle before the count drops on a remove
    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_REM) |-> ((head_reg == NIL) == (count_reg == '0)))
        else $error("head and element count disagree");

    a_tail_with_head: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("head and tail disagree on emptiness");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> (count_reg == NIL))
        else $error("full reported below capacity");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linked_list_set_table: directed and random add/remove/search items.
module tb_top;
    import lls_pkg::*;

    localparam int CAP            = 16;
    localparam int NIL            = CAP;
    localparam int CNT_W          = $clog2(CAP + 1);
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [CMD_W-1:0] CMD_SEARCH     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH_ALT = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic                is_empty;
    } set_result_t;

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [CMD_W-1:0]          cmd   = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      busy;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic [CNT_W-1:0]          count;
    logic                      is_empty;

    always #4 clk = ~clk;

    linked_list_set_table #(
        .CAPACITY   (CAP),
        .ELEM_WIDTH (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .value    (value),
        .done     (done),
        .status   (status),
        .count    (count),
        .is_empty (is_empty)
    );

    // shadow node table
    logic [VALUE_W-1:0] node_val [CAP];
    int                 node_nxt [CAP];
    int                 node_prv [CAP];
    int                 head_idx;
    int                 tail_idx;
    int                 free_idx;
    int                 elem_cnt;

    set_result_t        pending_results[$];
    logic [VALUE_W-1:0] value_pool[$];
    int                 idle_pct     = 0;
    int                 quiet_cycles = 0;
    int                 n_errors     = 0;
    int                 n_results    = 0;
    int                 n_adds       = 0;
    int                 n_removes    = 0;
    int                 n_searches   = 0;
    int                 n_full       = 0;
    int                 n_dup        = 0;
    int                 n_miss       = 0;

    function automatic void table_reset();
        for (int i = 0; i < CAP; i++)
        begin
            node_val[i] = '0;
            node_nxt[i] = i + 1;
            node_prv[i] = (i == 0) ? NIL : i - 1;
        end
        head_idx = NIL;
        tail_idx = NIL;
        free_idx = 0;
        elem_cnt = 0;
    endfunction

    function automatic int table_find(logic [VALUE_W-1:0] v);
        int cur;
        cur = head_idx;
        for (int s = 0; s < CAP && cur < NIL; s++)
        begin
            if (node_val[cur] == v)
                return cur;
            cur = node_nxt[cur];
        end
        return NIL;
    endfunction

    function automatic set_result_t table_apply(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
        set_result_t r;
        int          n;
        int          p;
        int          q;
        r.status = ST_DONE;
        n = table_find(v);
        case (c)
            CMD_ADD:
            begin
                n_adds++;
                if (n != NIL)
                begin
                    r.status = ST_MISS;
                    n_dup++;
                end
                else if (elem_cnt >= CAP || free_idx >= NIL)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    n = free_idx;
                    free_idx = node_nxt[n];
                    node_val[n] = v;
                    node_nxt[n] = NIL;
                    node_prv[n] = tail_idx;
                    if (tail_idx < NIL)
                        node_nxt[tail_idx] = n;
                    else
                        head_idx = n;
                    tail_idx = n;
                    elem_cnt++;
                end
            end
            CMD_REMOVE:
            begin
                n_removes++;
                if (n == NIL)
                begin
                    r.status = ST_MISS;
                    n_miss++;
                end
                else
                begin
                    p = node_prv[n];
                    q = node_nxt[n];
                    if (p < NIL)
                        node_nxt[p] = q;
                    else
                        head_idx = q;
                    if (q < NIL)
                        node_prv[q] = p;
                    else
                        tail_idx = p;
                    node_nxt[n] = free_idx;
                    node_prv[n] = NIL;
                    free_idx = n;
                    if (elem_cnt > 0)
                        elem_cnt--;
                end
            end
            default:
            begin
                n_searches++;
                if (n == NIL)
                begin
                    r.status = ST_MISS;
                    n_miss++;
                end
            end
        endcase
        r.count    = CNT_W'(elem_cnt);
        r.is_empty = (head_idx >= NIL);
        return r;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        cmd   <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(table_apply(c, v));
    endtask

    function automatic logic [VALUE_W-1:0] fresh_value();
        logic [VALUE_W-1:0] v;
        do
            v = $urandom;
        while (table_find(v) != NIL);
        return v;
    endfunction

    task automatic test_empty_table();
        send_item(CMD_SEARCH, 32'h1234_5678);
        send_item(CMD_REMOVE, 32'h0000_0000);
        send_item(CMD_SEARCH_ALT, 32'hffff_ffff);
    endtask

    // fills to capacity, then full and duplicate-while-full
    task automatic test_fill_to_full(output logic [VALUE_W-1:0] last_val);
        logic [VALUE_W-1:0] v;
        send_item(CMD_ADD, 32'h0000_0000);
        send_item(CMD_ADD, 32'hffff_ffff);
        send_item(CMD_ADD, 32'h8000_0000);
        send_item(CMD_ADD, 32'h7fff_ffff);
        send_item(CMD_ADD, 32'h5555_5555);
        send_item(CMD_ADD, 32'haaaa_aaaa);
        send_item(CMD_ADD, 32'h0000_0001);
        v = '0;
        for (int i = 0; i < CAP - 7; i++)
        begin
            v = fresh_value();
            send_item(CMD_ADD, v);
        end
        last_val = v;
        send_item(CMD_ADD, fresh_value());
        send_item(CMD_ADD, 32'h8000_0000);
        send_item(CMD_SEARCH_ALT, 32'h7fff_ffff);
    endtask

    task automatic test_unlink(input logic [VALUE_W-1:0] tail_val);
        send_item(CMD_REMOVE, 32'h0000_0000);
        send_item(CMD_REMOVE, tail_val);
        send_item(CMD_REMOVE, 32'h5555_5555);
        send_item(CMD_SEARCH, 32'h5555_5555);
        send_item(CMD_ADD, 32'h5555_5555);
    endtask

    task automatic test_random(input int n_items, input int pct, input int pool_size);
        int                 r;
        logic [CMD_W-1:0]   c;
        logic [VALUE_W-1:0] v;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
                c = CMD_ADD;
            else if (r < 68)
                c = CMD_REMOVE;
            else if (r < 95)
                c = CMD_SEARCH;
            else
                c = CMD_SEARCH_ALT;
            if ($urandom_range(99) < 85)
                v = value_pool[$urandom_range(pool_size - 1)];
            else
                v = $urandom;
            send_item(c, v);
        end
    endtask

    // removes everything in random order, the last one as a sole node
    task automatic test_drain();
        logic [VALUE_W-1:0] live[$];
        int                 cur;
        int                 k;
        idle_pct = 7;
        cur = head_idx;
        while (cur < NIL)
        begin
            live.push_back(node_val[cur]);
            cur = node_nxt[cur];
        end
        while (live.size() != 0)
        begin
            k = $urandom_range(live.size() - 1);
            send_item(CMD_REMOVE, live[k]);
            live.delete(k);
        end
        send_item(CMD_SEARCH, 32'h0000_0000);
    endtask

    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d count=%0d is_empty=%0d",
                         $time, status, count, is_empty);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                    n_errors++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: count expected %0d, got %0d", $time, want.count, count);
                    n_errors++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0d, got %0d",
                             $time, want.is_empty, is_empty);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [VALUE_W-1:0] tail_val;
        table_reset();
        for (int i = 0; i < 24; i++)
            value_pool.push_back($urandom);
        value_pool[3] = 32'h8000_0000;
        value_pool[7] = 32'h7fff_ffff;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_fill_to_full(tail_val);
        test_unlink(tail_val);
        test_random(150, 0, 24);
        test_random(150, 84, 10);
        test_random(150, 7, 20);
        test_drain();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAP + 6) @(posedge clk);

        $display("Checked %0d results: %0d adds (%0d full, %0d duplicate), %0d removes,",
                 n_results, n_adds, n_full, n_dup, n_removes);
        $display("%0d searches, %0d misses, under no, heavy and light sender idling.",
                 n_searches, n_miss);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lls_pkg.sv
hdl/lls_node_mem.sv
hdl/linked_list_set_table.sv
tb/tb_top.sv
